// File: rtl/dedp_pkg.sv
package dedp_pkg;

    localparam int MAX_DIGITS_DEF = 3;

    localparam logic [15:0] PWM_PERIOD_RST  = 16'd1000;
    localparam logic [6:0]  GREEN_RATIO_RST = 7'd45;
    localparam logic [15:0] IDLE_LIMIT_RST  = 16'd300;

    localparam logic [6:0]  PERCENT_MAX = 7'd100;

    // Division by 100 as a multiplication by ceil(2^30 / 100) and a shift.
    // Exact for dividends below 2^23, which covers every dividend used here.
    localparam int          MAC_W       = 24;
    localparam int          RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100   = 24'd10737419;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_DEL  = 8'h7F;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic STATUS_APPLIED = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [1:0] {
        REG_PWM_PERIOD  = 2'd0,
        REG_GREEN_RATIO = 2'd1,
        REG_IDLE_LIMIT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic fire;
        logic bad;
    } commit_t;

endpackage

// File: rtl/dedp_mac.sv
module dedp_mac (
    input  logic                             clk,
    input  logic                             en,
    input  logic [dedp_pkg::MAC_W-1:0]       a,
    input  logic [dedp_pkg::MAC_W-1:0]       b,
    input  logic [3:0]                       c,
    output logic [2*dedp_pkg::MAC_W-1:0]     p
);

    localparam int PW = 2 * dedp_pkg::MAC_W;

    logic [PW-1:0] p_reg;
    logic [PW-1:0] p_next;

    assign p_next = PW'(a) * PW'(b) + PW'(c);
    assign p      = p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

endmodule

// File: rtl/dedp_entry.sv
module dedp_entry #(
    parameter int MAX_DIGITS = dedp_pkg::MAX_DIGITS_DEF,
    localparam int CW = $clog2(MAX_DIGITS + 1),
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     func,
    input  logic [7:0]               char_code,
    input  logic [15:0]              idle_limit,
    input  logic [IW-1:0]            rd_idx,
    output logic [3:0]               rd_digit,
    output dedp_pkg::commit_t        evt,
    output logic [CW-1:0]            evt_count
);

    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_DIGITS);

    logic [3:0]    digit_store [MAX_DIGITS];
    logic [CW-1:0] digit_count_reg;
    logic [CW-1:0] digit_count_next;
    logic          entry_bad_reg;
    logic          entry_bad_next;
    logic [15:0]   idle_count_reg;
    logic [15:0]   idle_count_next;
    logic          pending;
    logic          is_digit;
    logic          is_space;
    logic          is_erase;
    logic          store_we;
    logic          fire;

    assign pending  = (digit_count_reg != '0) || entry_bad_reg;
    assign is_digit = (char_code >= dedp_pkg::CH_ZERO) && (char_code <= dedp_pkg::CH_NINE);
    assign is_space = (char_code == dedp_pkg::CH_CR) || (char_code == dedp_pkg::CH_LF) ||
                      (char_code == dedp_pkg::CH_SP) || (char_code == dedp_pkg::CH_TAB);
    assign is_erase = (char_code == dedp_pkg::CH_BS) || (char_code == dedp_pkg::CH_DEL);

    always_comb
    begin
        digit_count_next = digit_count_reg;
        entry_bad_next   = entry_bad_reg;
        idle_count_next  = idle_count_reg;
        store_we         = 1'b0;
        fire             = 1'b0;
        if (accept)
        begin
            if (func == dedp_pkg::FUNC_TICK)
            begin
                if (idle_count_reg != 16'hFFFF)
                begin
                    idle_count_next = idle_count_reg + 16'd1;
                end
                fire = pending && (idle_count_next >= idle_limit);
            end
            else
            begin
                idle_count_next = '0;
                priority if (is_digit)
                begin
                    if (!entry_bad_reg)
                    begin
                        if (digit_count_reg < COUNT_MAX)
                        begin
                            store_we         = 1'b1;
                            digit_count_next = digit_count_reg + CW'(1);
                        end
                        else
                        begin
                            entry_bad_next = 1'b1;
                        end
                    end
                end
                else if (is_space)
                begin
                    fire = pending;
                end
                else if (is_erase)
                begin
                    if (entry_bad_reg)
                    begin
                        digit_count_next = '0;
                        entry_bad_next   = 1'b0;
                    end
                    else if (digit_count_reg != '0)
                    begin
                        digit_count_next = digit_count_reg - CW'(1);
                    end
                end
                else
                begin
                    entry_bad_next = 1'b1;
                end
            end
            if (fire)
            begin
                digit_count_next = '0;
                entry_bad_next   = 1'b0;
            end
        end
    end

    assign evt.fire  = fire;
    assign evt.bad   = entry_bad_reg;
    assign evt_count = digit_count_reg;
    assign rd_digit  = digit_store[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= '0;
            entry_bad_reg   <= 1'b0;
            idle_count_reg  <= '0;
        end
        else
        begin
            digit_count_reg <= digit_count_next;
            entry_bad_reg   <= entry_bad_next;
            idle_count_reg  <= idle_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            digit_store[digit_count_reg[IW-1:0]] <= 4'(char_code - dedp_pkg::CH_ZERO);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= COUNT_MAX)
        else $error("Digit count exceeds its maximum.");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (digit_count_reg == '0) && !entry_bad_reg)
        else $error("Entry not cleared after a commit.");

    a_fire_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> pending)
        else $error("Commit without a pending entry.");

endmodule

// File: rtl/decimal_entry_to_dual_pwm_unit.sv
// Decimal entry to dual PWM compare values. Each input word is a character
// or a one-millisecond tick; a word that does not commit the entry leaves
// tready high. A committing word keeps tready low while the single shared
// 24 x 24 multiply-add unit builds the decimal value one digit per cycle and
// then forms both compare values, each division by 100 done as a reciprocal
// multiplication; an invalid entry ends these steps early or skips them. The
// result waits in an output register; a new commit holds in its last step
// until that register is free.
module decimal_entry_to_dual_pwm_unit #(
    parameter int MAX_DIGITS = dedp_pkg::MAX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // percent[6:0], red_compare[22:7],
                                        // green_compare[38:23], zero[39]
    output logic [0:0]  m_axis_tuser,   // status[0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int MW = dedp_pkg::MAC_W;
    localparam int SH = dedp_pkg::RECIP_SHIFT;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHK,
        ST_RDIV,
        ST_GMUL,
        ST_GDIV,
        ST_GSCL,
        ST_GSDIV,
        ST_FIN,
        ST_HOLD
    } state_t;

    state_t        state_reg;
    logic [15:0]   period_reg;
    logic [6:0]    ratio_reg;
    logic [15:0]   limit_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic          invalid_reg;
    logic [6:0]    value_reg;
    logic [15:0]   red_reg;
    logic [15:0]   green_reg;
    logic          out_valid_reg;
    logic [39:0]   out_data_reg;
    logic          out_user_reg;

    logic              accept;
    dedp_pkg::commit_t evt;
    logic [CW-1:0]     evt_count;
    logic [3:0]        rd_digit;
    logic [6:0]        ratio_sat;
    logic              mac_en;
    logic [MW-1:0]     mac_a;
    logic [MW-1:0]     mac_b;
    logic [3:0]        mac_c;
    logic [2*MW-1:0]   mac_p;
    logic [MW-1:0]     p_low;
    logic [15:0]       quot;
    logic              slot_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ratio_sat     = (ratio_reg > dedp_pkg::PERCENT_MAX) ? dedp_pkg::PERCENT_MAX
                                                               : ratio_reg;
    assign p_low         = mac_p[MW-1:0];
    assign quot          = mac_p[SH+15:SH];
    assign slot_free     = !out_valid_reg || m_axis_tready;

    dedp_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (s_axis_tuser[0]),
        .char_code  (s_axis_tdata),
        .idle_limit (limit_reg),
        .rd_idx     (idx_reg[IW-1:0]),
        .rd_digit   (rd_digit),
        .evt        (evt),
        .evt_count  (evt_count)
    );

    dedp_mac u_mac (
        .clk (clk),
        .en  (mac_en),
        .a   (mac_a),
        .b   (mac_b),
        .c   (mac_c),
        .p   (mac_p)
    );

    always_comb
    begin
        mac_en = 1'b1;
        mac_a  = '0;
        mac_b  = '0;
        mac_c  = '0;
        unique case (state_reg)
            ST_ACC:
            begin
                mac_a = (idx_reg == '0) ? '0 : p_low;
                mac_b = MW'(10);
                mac_c = rd_digit;
            end
            ST_CHK:
            begin
                mac_a = MW'(period_reg);
                mac_b = p_low;
            end
            ST_RDIV, ST_GDIV, ST_GSDIV:
            begin
                mac_a = p_low;
                mac_b = dedp_pkg::RECIP_100;
            end
            ST_GMUL:
            begin
                mac_a = MW'(value_reg);
                mac_b = MW'(ratio_sat);
            end
            ST_GSCL:
            begin
                mac_a = MW'(period_reg);
                mac_b = MW'(mac_p[SH+6:SH]);
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= dedp_pkg::PWM_PERIOD_RST;
            ratio_reg     <= dedp_pkg::GREEN_RATIO_RST;
            limit_reg     <= dedp_pkg::IDLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == dedp_pkg::REG_PWM_PERIOD)
            begin
                period_reg <= cfg_wdata;
            end
            if (cfg_idx == dedp_pkg::REG_GREEN_RATIO)
            begin
                ratio_reg <= cfg_wdata[6:0];
            end
            if (cfg_idx == dedp_pkg::REG_IDLE_LIMIT)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            invalid_reg   <= 1'b0;
            value_reg     <= '0;
            red_reg       <= '0;
            green_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (state_reg != ST_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && evt.fire)
                    begin
                        cnt_reg     <= evt_count;
                        idx_reg     <= '0;
                        invalid_reg <= evt.bad || (evt_count == '0);
                        state_reg   <= (evt.bad || (evt_count == '0)) ? ST_HOLD : ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if ((idx_reg + CW'(1)) == cnt_reg)
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    value_reg <= p_low[6:0];
                    if (p_low > MW'(dedp_pkg::PERCENT_MAX))
                    begin
                        invalid_reg <= 1'b1;
                        state_reg   <= ST_HOLD;
                    end
                    else
                    begin
                        state_reg <= ST_RDIV;
                    end
                end
                ST_RDIV:
                begin
                    state_reg <= ST_GMUL;
                end
                ST_GMUL:
                begin
                    red_reg   <= period_reg - quot;
                    state_reg <= ST_GDIV;
                end
                ST_GDIV:
                begin
                    state_reg <= ST_GSCL;
                end
                ST_GSCL:
                begin
                    state_reg <= ST_GSDIV;
                end
                ST_GSDIV:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    green_reg <= period_reg - quot;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (invalid_reg)
                        begin
                            out_user_reg <= dedp_pkg::STATUS_INVALID;
                            out_data_reg <= '0;
                        end
                        else
                        begin
                            out_user_reg <= dedp_pkg::STATUS_APPLIED;
                            out_data_reg <= {1'b0, green_reg, red_reg, value_reg};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_user_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == dedp_pkg::STATUS_INVALID)
        |-> (m_axis_tdata == '0))
        else $error("Invalid result carries a nonzero payload.");

    a_applied_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == dedp_pkg::STATUS_APPLIED)
        |-> (m_axis_tdata[6:0] <= dedp_pkg::PERCENT_MAX) &&
            (m_axis_tdata[38:23] >= m_axis_tdata[22:7]))
        else $error("Applied result out of range or green above red duty.");

    a_commit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && evt.fire |=> (state_reg == ST_ACC) || (state_reg == ST_HOLD))
        else $error("Commit did not start the sequencer.");

    a_hold_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) && slot_free |=> m_axis_tvalid)
        else $error("Result not presented after the final step.");

endmodule
